@@ rtl/iol_pkg.sv @@
// shared types, constants and helpers for the indexed order list
package iol_pkg;

  localparam int unsigned MAX_NODES = 256;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned LINK_W    = NODE_W + 1;
  localparam int unsigned CELL_W    = 4;
  localparam int unsigned SLOT_W    = NODE_W - CELL_W;
  localparam int unsigned NUM_CELLS = 1 << CELL_W;
  localparam int unsigned SLOTS     = 1 << SLOT_W;

  localparam logic [LINK_W-1:0] NONE_NODE        = LINK_W'(MAX_NODES);
  localparam logic [LINK_W-1:0] NODE_COUNT_RESET = LINK_W'(MAX_NODES);

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_NODE_COUNT = 1'b0;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_REMOVE     = 4'd2,
    CMD_MOVE_FRONT = 4'd3,
    CMD_MOVE_BACK  = 4'd4,
    CMD_POP_FRONT  = 4'd5,
    CMD_POP_BACK   = 4'd6,
    CMD_CONTAINS   = 4'd7,
    CMD_CLEAR      = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_RANGE    = 3'd2,
    STAT_LINKED   = 3'd3,
    STAT_UNLINKED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EXEC
  } ctrl_state_e;

  typedef enum logic {
    PKT_READ,
    PKT_WRITE
  } pkt_kind_e;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [NODE_W-1:0] node_index;
  } in_item_t;

  typedef struct packed {
    logic [LINK_W-1:0] result_node;
    logic              present;
    status_e           status;
    logic [LINK_W-1:0] list_length;
  } out_item_t;

  // one transaction travelling down the cell chain
  typedef struct packed {
    logic              valid;
    pkt_kind_e         kind;
    logic [NODE_W-1:0] node;
    logic [LINK_W-1:0] rd_next;
    logic [LINK_W-1:0] rd_prev;
    logic              rd_linked;
    logic              self_we;
    logic [LINK_W-1:0] self_next;
    logic [LINK_W-1:0] self_prev;
    logic              flag_set;
    logic              flag_clr;
    logic              clear_all;
    logic              na_we;
    logic [NODE_W-1:0] na_node;
    logic [LINK_W-1:0] na_val;
    logic              nb_we;
    logic [NODE_W-1:0] nb_node;
    logic [LINK_W-1:0] nb_val;
    logic              pa_we;
    logic [NODE_W-1:0] pa_node;
    logic [LINK_W-1:0] pa_val;
    logic              pb_we;
    logic [NODE_W-1:0] pb_node;
    logic [LINK_W-1:0] pb_val;
  } pkt_t;

  function automatic logic is_node(logic [LINK_W-1:0] v);
    return !v[LINK_W-1];
  endfunction

endpackage

@@ rtl/iol_cell.sv @@
// one chain cell: link and linked-flag storage for a slice of nodes
module iol_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [iol_pkg::CELL_W-1:0] cell_id_i,
  input  iol_pkg::pkt_t              pkt_i,
  output iol_pkg::pkt_t              pkt_o
);
  import iol_pkg::*;

  logic [LINK_W-1:0] next_q [SLOTS];
  logic [LINK_W-1:0] prev_q [SLOTS];
  logic [SLOTS-1:0]  flag_q, flag_d;
  pkt_t              pkt_q, pkt_d;
  logic              wr;
  logic              rd_hit;
  logic [SLOT_W-1:0] rd_slot;

  assign wr      = pkt_i.valid && (pkt_i.kind == PKT_WRITE);
  assign rd_hit  = pkt_i.valid && (pkt_i.kind == PKT_READ)
                   && (pkt_i.node[NODE_W-1:SLOT_W] == cell_id_i);
  assign rd_slot = pkt_i.node[SLOT_W-1:0];

  // fill in the links of the requested node as the read passes by
  always_comb begin
    pkt_d = pkt_i;
    if (rd_hit) begin
      pkt_d.rd_next   = next_q[rd_slot];
      pkt_d.rd_prev   = prev_q[rd_slot];
      pkt_d.rd_linked = flag_q[rd_slot];
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    logic [NODE_W-1:0] id;
    logic              self_hit;

    assign id       = {cell_id_i, SLOT_W'(s)};
    assign self_hit = wr && (pkt_i.node == id);

    always_ff @(posedge clk_i) begin
      if (self_hit && pkt_i.self_we) begin
        next_q[s] <= pkt_i.self_next;
      end else if (wr && pkt_i.na_we && (pkt_i.na_node == id)) begin
        next_q[s] <= pkt_i.na_val;
      end else if (wr && pkt_i.nb_we && (pkt_i.nb_node == id)) begin
        next_q[s] <= pkt_i.nb_val;
      end
    end

    always_ff @(posedge clk_i) begin
      if (self_hit && pkt_i.self_we) begin
        prev_q[s] <= pkt_i.self_prev;
      end else if (wr && pkt_i.pa_we && (pkt_i.pa_node == id)) begin
        prev_q[s] <= pkt_i.pa_val;
      end else if (wr && pkt_i.pb_we && (pkt_i.pb_node == id)) begin
        prev_q[s] <= pkt_i.pb_val;
      end
    end

    always_comb begin
      if (wr && pkt_i.clear_all) begin
        flag_d[s] = 1'b0;
      end else if (self_hit && pkt_i.flag_set) begin
        flag_d[s] = 1'b1;
      end else if (self_hit && pkt_i.flag_clr) begin
        flag_d[s] = 1'b0;
      end else begin
        flag_d[s] = flag_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
      pkt_q  <= '0;
    end else begin
      flag_q <= flag_d;
      pkt_q  <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule

@@ rtl/iol_ctrl.sv @@
// command sequencer: head, tail, count, list updates and result register
module iol_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  iol_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output iol_pkg::out_item_t         out_data_o,
  input  logic [iol_pkg::LINK_W-1:0] node_count_i,
  output iol_pkg::pkt_t              inj_o,
  input  iol_pkg::pkt_t              ret_i
);
  import iol_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [3:0]        cmd_q;
  logic [NODE_W-1:0] node_q;
  logic [LINK_W-1:0] rd_next_q, rd_prev_q;
  logic              rd_linked_q;
  logic [LINK_W-1:0] head_q, tail_q, count_q;
  logic [LINK_W-1:0] head_d, tail_d, count_d;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              accept, capture, commit, out_free, ret_read;
  logic              in_pop;
  logic [NODE_W-1:0] rd_node;

  logic              is_pop, in_range;
  logic [LINK_W-1:0] pop_end, tgt, nx, pv;
  logic [LINK_W-1:0] d_head, d_tail, d_count;
  logic [LINK_W-1:0] base_h, base_t, base_c;
  logic              do_detach, do_front, do_back, do_clear;
  logic [LINK_W-1:0] res_node;
  logic              res_present;
  status_e           res_status;
  pkt_t              wr_pkt, rd_pkt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ret_read = ret_i.valid && (ret_i.kind == PKT_READ);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_WAIT;
      ST_WAIT: if (ret_read) state_d = ST_EXEC;
      ST_EXEC: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    capture    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_WAIT: capture = ret_read;
      ST_EXEC: commit  = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  // read transaction: pops read the end node, everything else the named node
  assign in_pop = (in_data_i.cmd == CMD_POP_FRONT) || (in_data_i.cmd == CMD_POP_BACK);

  always_comb begin
    if (in_pop) begin
      rd_node = (in_data_i.cmd == CMD_POP_FRONT) ? head_q[NODE_W-1:0] : tail_q[NODE_W-1:0];
    end else begin
      rd_node = in_data_i.node_index;
    end
    rd_pkt       = '0;
    rd_pkt.valid = 1'b1;
    rd_pkt.kind  = PKT_READ;
    rd_pkt.node  = rd_node;
  end

  // command execution from the captured links
  always_comb begin
    is_pop   = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK);
    pop_end  = (cmd_q == CMD_POP_FRONT) ? head_q : tail_q;
    tgt      = is_pop ? pop_end : {1'b0, node_q};
    nx       = is_node(rd_next_q) ? rd_next_q : NONE_NODE;
    pv       = is_node(rd_prev_q) ? rd_prev_q : NONE_NODE;
    in_range = {1'b0, node_q} < node_count_i;

    d_head  = is_node(pv) ? head_q : nx;
    d_tail  = is_node(nx) ? tail_q : pv;
    d_count = (count_q != '0) ? (count_q - LINK_W'(1)) : count_q;

    do_detach   = 1'b0;
    do_front    = 1'b0;
    do_back     = 1'b0;
    do_clear    = 1'b0;
    res_node    = {1'b0, node_q};
    res_present = 1'b0;
    res_status  = STAT_OK;

    if (is_pop) begin
      if (is_node(pop_end) && rd_linked_q) begin
        do_detach   = 1'b1;
        res_node    = pop_end;
        res_present = 1'b1;
      end else begin
        res_node   = NONE_NODE;
        res_status = STAT_EMPTY;
      end
    end else if (cmd_q == CMD_CLEAR) begin
      do_clear = 1'b1;
      res_node = NONE_NODE;
    end else if (cmd_q > CMD_CLEAR) begin
      res_node = NONE_NODE;
    end else if (!in_range) begin
      res_status = STAT_RANGE;
    end else if (cmd_q == CMD_CONTAINS) begin
      res_present = rd_linked_q;
    end else if ((cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK)) begin
      if (rd_linked_q) begin
        res_status = STAT_LINKED;
      end else if (cmd_q == CMD_PUSH_FRONT) begin
        do_front = 1'b1;
      end else begin
        do_back = 1'b1;
      end
    end else if (!rd_linked_q) begin
      res_status = STAT_UNLINKED;
    end else if (cmd_q == CMD_REMOVE) begin
      do_detach = 1'b1;
    end else if (cmd_q == CMD_MOVE_FRONT) begin
      if (head_q != tgt) begin
        do_detach = 1'b1;
        do_front  = 1'b1;
      end
    end else begin
      if (tail_q != tgt) begin
        do_detach = 1'b1;
        do_back   = 1'b1;
      end
    end

    base_h = do_detach ? d_head  : head_q;
    base_t = do_detach ? d_tail  : tail_q;
    base_c = do_detach ? d_count : count_q;

    head_d  = base_h;
    tail_d  = base_t;
    count_d = base_c;

    wr_pkt      = '0;
    wr_pkt.kind = PKT_WRITE;
    wr_pkt.node = tgt[NODE_W-1:0];

    if (do_detach) begin
      wr_pkt.na_we   = is_node(pv);
      wr_pkt.na_node = pv[NODE_W-1:0];
      wr_pkt.na_val  = nx;
      wr_pkt.pa_we   = is_node(nx);
      wr_pkt.pa_node = nx[NODE_W-1:0];
      wr_pkt.pa_val  = pv;
    end

    if (do_front) begin
      wr_pkt.self_we   = 1'b1;
      wr_pkt.self_prev = NONE_NODE;
      wr_pkt.self_next = base_h;
      wr_pkt.pb_we     = is_node(base_h);
      wr_pkt.pb_node   = base_h[NODE_W-1:0];
      wr_pkt.pb_val    = tgt;
      if (!is_node(base_h)) tail_d = tgt;
      head_d  = tgt;
      count_d = base_c + LINK_W'(1);
    end

    if (do_back) begin
      wr_pkt.self_we   = 1'b1;
      wr_pkt.self_next = NONE_NODE;
      wr_pkt.self_prev = base_t;
      wr_pkt.nb_we     = is_node(base_t);
      wr_pkt.nb_node   = base_t[NODE_W-1:0];
      wr_pkt.nb_val    = tgt;
      if (!is_node(base_t)) head_d = tgt;
      tail_d  = tgt;
      count_d = base_c + LINK_W'(1);
    end

    if (do_clear) begin
      head_d  = NONE_NODE;
      tail_d  = NONE_NODE;
      count_d = '0;
    end

    wr_pkt.flag_set  = do_front || do_back;
    wr_pkt.flag_clr  = do_detach && !(do_front || do_back);
    wr_pkt.clear_all = do_clear;
    wr_pkt.valid     = do_detach || do_front || do_back || do_clear;
  end

  always_comb begin
    if (accept) begin
      inj_o = rd_pkt;
    end else if (commit) begin
      inj_o = wr_pkt;
    end else begin
      inj_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= NONE_NODE;
      tail_q      <= NONE_NODE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_data_i.cmd;
      node_q <= in_data_i.node_index;
    end
    if (capture) begin
      rd_next_q   <= ret_i.rd_next;
      rd_prev_q   <= ret_i.rd_prev;
      rd_linked_q <= ret_i.rd_linked;
    end
    if (commit) begin
      out_q.result_node <= res_node;
      out_q.present     <= res_present;
      out_q.status      <= res_status;
      out_q.list_length <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NONE_NODE)
    else $error("linked count above pool size");

  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((head_q == NONE_NODE) == (count_q == '0)) && ((tail_q == NONE_NODE) == (count_q == '0)))
    else $error("head, tail and count disagree on emptiness");

  a_read_return_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_read |-> (state_q == ST_WAIT))
    else $error("read transaction left the chain outside of wait");

  a_commit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed command produced no result");

endmodule

@@ rtl/indexed_doubly_linked_order_list_core.sv @@
// top level: register port, cell chain and command sequencer
// Keeps a recency order over 256 node indices as a doubly linked list. A
// command's read transaction enters the first cell on the accepting edge and
// ripples through the 16-cell chain, one cell after another (each cell holding
// the links and linked flags of 16 nodes); the returned links are then
// captured, and a commit step updates the head, tail and count, loads the
// result register and launches the link writes, which follow down the chain
// ahead of the next read. A new command is accepted only once the previous one
// has committed, so the core never takes a new command while one is in flight;
// the commit waits while the output register holds a result that has
// not been taken, and the input stalls for as long. Clear takes effect through
// the linked flags as its transaction passes each cell. No clearing pass is
// needed after reset. node_count sits at byte address 0 of the register port.
module indexed_doubly_linked_order_list_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  iol_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output iol_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iol_pkg::PADDR_W-1:0] paddr,
  input  logic [iol_pkg::PDATA_W-1:0] pwdata,
  output logic [iol_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import iol_pkg::*;

  logic [LINK_W-1:0] node_count_q;
  logic              reg_sel;
  pkt_t              chain [NUM_CELLS+1];

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_NODE_COUNT);
  assign prdata  = reg_sel ? PDATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count_q <= pwdata[LINK_W-1:0];
    end
  end

  iol_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .node_count_i (node_count_q),
    .inj_o        (chain[0]),
    .ret_i        (chain[NUM_CELLS])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    iol_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CELL_W'(k)),
      .pkt_i     (chain[k]),
      .pkt_o     (chain[k+1])
    );
  end

endmodule

@@ test/tb.sv @@
// self-checking testbench for the indexed doubly linked order list core
package iol_tb_pkg;
  import iol_pkg::*;

  // predicted list state plus the queue of results still owed by the core
  class order_list_book;
    logic [LINK_W-1:0] next_of [MAX_NODES];
    logic [LINK_W-1:0] prev_of [MAX_NODES];
    bit                linked  [MAX_NODES];
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] length;
    logic [LINK_W-1:0] node_limit;
    out_item_t         owed_q [$];
    int                errors;
    int                checked;

    function new();
      drop_all();
      node_limit = NODE_COUNT_RESET;
      errors     = 0;
      checked    = 0;
    endfunction

    function void drop_all();
      foreach (linked[i]) linked[i] = 1'b0;
      head   = NONE_NODE;
      tail   = NONE_NODE;
      length = '0;
    endfunction

    function bit real_node(logic [LINK_W-1:0] v);
      return v < NONE_NODE;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void unlink(logic [NODE_W-1:0] n);
      logic [LINK_W-1:0] nx;
      logic [LINK_W-1:0] pv;
      nx = real_node(next_of[n]) ? next_of[n] : NONE_NODE;
      pv = real_node(prev_of[n]) ? prev_of[n] : NONE_NODE;
      if (real_node(pv)) next_of[pv[NODE_W-1:0]] = nx;
      else head = nx;
      if (real_node(nx)) prev_of[nx[NODE_W-1:0]] = pv;
      else tail = pv;
      linked[n] = 1'b0;
      if (length != 0) length = length - 1'b1;
    endfunction

    function void link_front(logic [NODE_W-1:0] n);
      prev_of[n] = NONE_NODE;
      next_of[n] = head;
      if (real_node(head)) prev_of[head[NODE_W-1:0]] = LINK_W'(n);
      else tail = LINK_W'(n);
      head      = LINK_W'(n);
      linked[n] = 1'b1;
      length    = length + 1'b1;
    endfunction

    function void link_back(logic [NODE_W-1:0] n);
      next_of[n] = NONE_NODE;
      prev_of[n] = tail;
      if (real_node(tail)) next_of[tail[NODE_W-1:0]] = LINK_W'(n);
      else head = LINK_W'(n);
      tail      = LINK_W'(n);
      linked[n] = 1'b1;
      length    = length + 1'b1;
    endfunction

    // apply one accepted command and queue the result it must produce
    function void note_cmd(in_item_t it);
      out_item_t         r;
      logic [NODE_W-1:0] n;
      logic [LINK_W-1:0] n9;
      logic [LINK_W-1:0] end_node;
      n             = it.node_index;
      n9            = LINK_W'(n);
      r.result_node = n9;
      r.present     = 1'b0;
      r.status      = STAT_OK;
      if (it.cmd == CMD_POP_FRONT || it.cmd == CMD_POP_BACK) begin
        end_node = (it.cmd == CMD_POP_FRONT) ? head : tail;
        if (real_node(end_node) && linked[end_node[NODE_W-1:0]]) begin
          unlink(end_node[NODE_W-1:0]);
          r.result_node = end_node;
          r.present     = 1'b1;
        end else begin
          r.result_node = NONE_NODE;
          r.status      = STAT_EMPTY;
        end
      end else if (it.cmd == CMD_CLEAR) begin
        drop_all();
        r.result_node = NONE_NODE;
      end else if (it.cmd > CMD_CLEAR) begin
        r.result_node = NONE_NODE;
      end else if (n9 >= node_limit) begin
        r.status = STAT_RANGE;
      end else if (it.cmd == CMD_CONTAINS) begin
        r.present = linked[n];
      end else if (it.cmd == CMD_PUSH_FRONT || it.cmd == CMD_PUSH_BACK) begin
        if (linked[n]) r.status = STAT_LINKED;
        else if (it.cmd == CMD_PUSH_FRONT) link_front(n);
        else link_back(n);
      end else if (!linked[n]) begin
        r.status = STAT_UNLINKED;
      end else if (it.cmd == CMD_REMOVE) begin
        unlink(n);
      end else if (it.cmd == CMD_MOVE_FRONT) begin
        if (head != n9) begin
          unlink(n);
          link_front(n);
        end
      end else begin
        if (tail != n9) begin
          unlink(n);
          link_back(n);
        end
      end
      r.list_length = length;
      owed_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (owed_q.size() == 0) begin
        report("result with no command outstanding");
        return;
      end
      want = owed_q.pop_front();
      if (got.result_node !== want.result_node)
        report($sformatf("result_node %0d, want %0d", got.result_node, want.result_node));
      if (got.present !== want.present)
        report($sformatf("present %0b, want %0b", got.present, want.present));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.list_length !== want.list_length)
        report($sformatf("list_length %0d, want %0d", got.list_length, want.list_length));
    endtask
  endclass
endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iol_pkg::*;
  import iol_tb_pkg::*;

  localparam logic [PADDR_W-1:0] NODE_COUNT_ADDR = PADDR_W'(4 * REG_NODE_COUNT);
  localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT        = 500;
  localparam int RAND_PER_PHASE = 145;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  order_list_book book;
  int             cycles = 0;
  int             sent_count = 0;
  bit             send_fast = 1'b0;

  indexed_doubly_linked_order_list_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [3:0] c, logic [NODE_W-1:0] n);
    in_item_t it;
    it.cmd        = c;
    it.node_index = n;
    return it;
  endfunction

  // mostly well-formed list traffic on nodes in range, some out of range
  function automatic in_item_t rand_cmd(int limit);
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      it.cmd = CMD_PUSH_FRONT;
    else if (pick < 44) it.cmd = CMD_PUSH_BACK;
    else if (pick < 54) it.cmd = CMD_REMOVE;
    else if (pick < 62) it.cmd = CMD_MOVE_FRONT;
    else if (pick < 70) it.cmd = CMD_MOVE_BACK;
    else if (pick < 78) it.cmd = CMD_POP_FRONT;
    else if (pick < 86) it.cmd = CMD_POP_BACK;
    else if (pick < 95) it.cmd = CMD_CONTAINS;
    else if (pick < 97) it.cmd = CMD_CLEAR;
    else it.cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    if ($urandom_range(0, 9) == 0) it.node_index = NODE_W'($urandom_range(0, MAX_NODES - 1));
    else it.node_index = NODE_W'($urandom_range(0, limit - 1));
    return it;
  endfunction

  task automatic send_cmd(in_item_t it);
    int gap;
    if (sent_count % 32 == 0) send_fast = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = send_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_cmd(it);
  endtask

  // stop offering and let every outstanding transaction come back
  task automatic finish_batch();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [LINK_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    book.node_limit = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side, with one long hold-off so the core backs up into the sender
  initial begin
    int gap;
    int taken;
    bit fast;
    taken = 0;
    fast  = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 32 == 0) fast = ($urandom_range(0, 3) == 0);
      gap = fast ? 0 : $urandom_range(0, 15);
      if (taken == HOLD_AT) gap = LONG_HOLD;
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      book.check_result(out_data_o);
      taken++;
    end
  end

  initial begin
    int limits [7];
    book        = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, bad requests, both ends, moves already in place, clear
    send_cmd(mk(CMD_POP_FRONT, 8'd0));
    send_cmd(mk(CMD_POP_BACK, 8'd255));
    send_cmd(mk(CMD_CONTAINS, 8'd0));
    send_cmd(mk(CMD_REMOVE, 8'd5));
    send_cmd(mk(CMD_MOVE_FRONT, 8'd5));
    send_cmd(mk(CMD_MOVE_BACK, 8'd5));
    send_cmd(mk(CMD_PUSH_FRONT, 8'd0));
    send_cmd(mk(CMD_PUSH_BACK, 8'd255));
    send_cmd(mk(CMD_PUSH_FRONT, 8'd0));
    send_cmd(mk(CMD_PUSH_BACK, 8'd128));
    send_cmd(mk(CMD_MOVE_FRONT, 8'd128));
    send_cmd(mk(CMD_MOVE_FRONT, 8'd128));
    send_cmd(mk(CMD_MOVE_BACK, 8'd255));
    send_cmd(mk(CMD_MOVE_BACK, 8'd0));
    send_cmd(mk(CMD_CONTAINS, 8'd255));
    send_cmd(mk(CMD_REMOVE, 8'd255));
    send_cmd(mk(CMD_UNKNOWN_LO, 8'd7));
    send_cmd(mk(CMD_UNKNOWN_HI, 8'd200));
    send_cmd(mk(CMD_POP_BACK, 8'd0));
    send_cmd(mk(CMD_POP_FRONT, 8'd0));
    send_cmd(mk(CMD_PUSH_FRONT, 8'd170));
    send_cmd(mk(CMD_CLEAR, 8'd85));
    send_cmd(mk(CMD_CONTAINS, 8'd170));
    send_cmd(mk(CMD_PUSH_BACK, 8'd100));
    send_cmd(mk(CMD_PUSH_BACK, 8'd200));
    finish_batch();

    // shrink below linked nodes: they are rejected by name but still pop
    write_node_count(LINK_W'(4));
    send_cmd(mk(CMD_CONTAINS, 8'd100));
    send_cmd(mk(CMD_PUSH_FRONT, 8'd4));
    send_cmd(mk(CMD_POP_FRONT, 8'd0));
    send_cmd(mk(CMD_POP_BACK, 8'd0));
    send_cmd(mk(CMD_PUSH_BACK, 8'd3));
    finish_batch();
    write_node_count(LINK_W'(1));
    send_cmd(mk(CMD_PUSH_FRONT, 8'd0));
    send_cmd(mk(CMD_PUSH_BACK, 8'd1));
    send_cmd(mk(CMD_POP_BACK, 8'd0));
    finish_batch();

    limits = '{2, 16, 256, 64, 1, 256, 0};
    limits[6] = $urandom_range(1, 256);
    for (int p = 0; p < 7; p++) begin
      write_node_count(LINK_W'(limits[p]));
      for (int k = 0; k < RAND_PER_PHASE; k++) send_cmd(rand_cmd(limits[p]));
      finish_batch();
    end

    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
